[rtl/core/sqpp_pkg.sv]
// ----------------------------------------------------------------------------
// sqpp_pkg
// Shared types and constants for the sorted parity-pop queue.
// ----------------------------------------------------------------------------
package sqpp_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 8;
  localparam int CAP_W  = 7;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(50);

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_TAKE_ODD  = 2'd1,
    OP_TAKE_EVEN = 2'd2,
    OP_UNUSED    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  typedef struct packed {
    logic              ins;
    logic              pop;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

[rtl/core/sorted_queue_parity_pop_top.sv]
// ----------------------------------------------------------------------------
// sorted_queue_parity_pop_top
// Sorted bounded queue with parity-gated removal of the head.
// ----------------------------------------------------------------------------
// One request is taken per clock while in_tready is high; its result goes
// to the output entry, or to the skid entry if that is held. All cells
// compare with the incoming value at once, so insert position and shift
// settle in parallel. A two-entry output buffer absorbs a stalled result
// side; in_tready drops only when both entries hold results not yet taken.
module sorted_queue_parity_pop_top
  import sqpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,   // capacity_limit
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // op[1:0], value[9:2], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata      // status[1:0], head_value[9:2],
                                     // entry_count[16:10], zero pad
);

  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  logic [16:0] out_r;
  logic [16:0] skid_r;
  logic        out_valid_r;
  logic        skid_valid_r;

  logic [1:0]        op;
  logic [DATA_W-1:0] in_value;
  logic              accept;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  lim_ext;
  logic              is_full;
  logic              empty;
  logic              head_odd;
  logic              match;
  cell_ctl_t         ctl;
  status_t           status;
  logic [DATA_W-1:0] head_value;
  logic [16:0]       result;

  logic [DATA_W-1:0] cell_val [DEPTH];
  logic              cell_lt  [DEPTH];

  assign op       = in_tdata[1:0];
  assign in_value = in_tdata[9:2];
  assign accept   = in_tvalid & in_tready;
  assign in_tready = ~skid_valid_r;

  assign cnt_ext  = CMP_W'(cnt_r);
  assign lim_ext  = (CMP_W'(cap_r) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_r);
  assign is_full  = cnt_ext >= lim_ext;
  assign empty    = (cnt_r == '0);
  assign head_odd = cell_val[0][0];
  assign match    = (op == OP_TAKE_ODD && head_odd) || (op == OP_TAKE_EVEN && !head_odd);

  always_comb begin
    ctl.ins    = 1'b0;
    ctl.pop    = 1'b0;
    ctl.value  = in_value;
    status     = ST_DONE;
    head_value = '0;
    cnt_nxt    = cnt_r;
    if (op == OP_INSERT) begin
      if (is_full) begin
        status     = ST_FULL;
        head_value = empty ? '0 : cell_val[0];
      end else begin
        ctl.ins    = accept;
        head_value = cell_lt[0] ? cell_val[0] : in_value;
        cnt_nxt    = cnt_r + CNT_W'(1);
      end
    end else if (empty) begin
      status = ST_EMPTY;
    end else if (match) begin
      ctl.pop    = accept;
      head_value = cell_val[0];
      cnt_nxt    = cnt_r - CNT_W'(1);
    end else begin
      status     = ST_MISMATCH;
      head_value = cell_val[0];
    end
  end

  logic [CMP_W-1:0] cnt_res_ext;
  assign cnt_res_ext = CMP_W'(cnt_nxt);
  assign result      = {cnt_res_ext[6:0], head_value, status};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              occ;
    logic              left_lt;
    logic [DATA_W-1:0] left_val;
    logic [DATA_W-1:0] right_val;

    assign occ = CNT_W'(i) < cnt_r;

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_val = in_value;
    end else begin : g_mid
      assign left_lt  = cell_lt[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    sqpp_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ),
      .left_lt   (left_lt),
      .left_val  (left_val),
      .right_val (right_val),
      .lt        (cell_lt[i]),
      .val       (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      cnt_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  logic out_free;
  assign out_free = ~out_valid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_free) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (accept) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) begin
        out_r <= skid_r;
      end
    end else if (accept) begin
      if (out_free) begin
        out_r <= result;
      end else begin
        skid_r <= result;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r};

endmodule

[rtl/core/sqpp_cell.sv]
// ----------------------------------------------------------------------------
// sqpp_cell
// One slot of the sorted chain: holds a value, shifts right on insert,
// shifts left on pop, and compares itself against the incoming value.
// ----------------------------------------------------------------------------
module sqpp_cell
  import sqpp_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic              occ,       // slot holds a live entry
  input  logic              left_lt,   // left neighbor stays put on insert
  input  logic [DATA_W-1:0] left_val,
  input  logic [DATA_W-1:0] right_val,
  output logic              lt,
  output logic [DATA_W-1:0] val
);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;

  assign lt  = occ & (val_r < ctl.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (!lt) begin
        val_nxt = left_lt ? ctl.value : left_val;
      end
    end else if (ctl.pop) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
